// ----- sv/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue: entry layout,
// index widths, status codes and sequencer states.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   // Heap geometry
   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;
   localparam int CHILD_W  = IDX_W + 2;

   // Entry fields
   localparam int TAG_W   = 32;
   localparam int PRIO_W  = 16;
   localparam int ENTRY_W = TAG_W + PRIO_W;

   // Stream widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 3;
   localparam int RSP_PAD_W  = RSP_DATA_W - ENTRY_W - CNT_W;

   // One heap element, tag in the low bits
   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic        [TAG_W-1:0]  tag;
   } entry_type;

   // Request kinds
   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_LD,
      ST_DN,
      ST_DN_CMP,
      ST_RESP
   } state_type;

endpackage

// ----- sv/mhpq_ram.sv -----
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap storage: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH  = 48,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, registered
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- sv/max_heap_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue. Each request pushes or pops one element;
// each request returns the top element, the element count and a status.
//
// Channel  Dir  Ports                      Content
// req      in   req_tvalid/tready/tdata/   tdata: item_tag, item_priority
//               tuser                      tuser: req_type
// rsp      out  rsp_tvalid/tready/tdata/   tdata: top_tag, top_priority,
//               tuser                             element_total
//                                          tuser: is_empty, status
//
// A push climbs one heap level at a time, reading the parent in ST_UP and
// comparing and writing in ST_UP_CMP; a pop first fetches the last element
// (ST_POP_RD, ST_POP_LD), then descends with a read in ST_DN and a
// compare/write in ST_DN_CMP per level, as the single heap memory needs.
// Reset clears the element count; heap memory is not cleared.
// A new request is taken while the previous result waits in the output
// register; the unit stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit
   import mhpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] item_tag, [47:32] item_priority
   input  logic                  req_tuser,   // [0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] top_tag, [47:32] top_priority,
                                              // [58:48] element_total, [63:59] zero
   output logic [RSP_USER_W-1:0] rsp_tuser    // [0] is_empty, [2:1] status
);

   // Sequencer and datapath registers
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   entry_type             carry_ff, carry_in;
   entry_type             top_ff, top_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // Memory ports
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;
   logic [IDX_W-1:0]      rd_addr_a, rd_addr_b;
   entry_type             rd_a, rd_b;

   // Index arithmetic and compares
   logic                  req_xfer;
   logic                  rsp_load;
   logic [IDX_W-1:0]      parent_idx;
   logic [CHILD_W-1:0]    left_idx, right_idx;
   logic                  left_ok, right_ok;
   logic                  pick_left, pick_right;
   logic signed [PRIO_W-1:0] best_prio;
   logic                  climb;
   entry_type             req_entry;

   assign req_xfer  = req_tvalid && req_tready;
   assign req_entry = entry_type'(req_tdata);
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign left_idx   = CHILD_W'({idx_ff, 1'b1});
   assign right_idx  = CHILD_W'({idx_ff, 1'b0}) + CHILD_W'(2);
   assign left_ok    = left_idx < CHILD_W'(count_ff);
   assign right_ok   = right_idx < CHILD_W'(count_ff);
   assign pick_left  = left_ok && (rd_a.prio > carry_ff.prio);
   assign best_prio  = pick_left ? rd_a.prio : carry_ff.prio;
   assign pick_right = right_ok && (rd_b.prio > best_prio);
   assign climb      = carry_ff.prio > rd_a.prio;

   mhpq_ram #(
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == REQ_PUSH) begin
                  state_in = (count_ff == CNT_W'(CAPACITY)) ? ST_RESP : ST_UP;
               end else begin
                  state_in = (count_ff == '0) ? ST_RESP : ST_POP_RD;
               end
            end
         end
         ST_UP:     state_in = (idx_ff == '0) ? ST_RESP : ST_UP_CMP;
         ST_UP_CMP: state_in = climb ? ST_UP : ST_RESP;
         ST_POP_RD: state_in = ST_POP_LD;
         ST_POP_LD: state_in = (count_ff == '0) ? ST_RESP : ST_DN;
         ST_DN:     state_in = left_ok ? ST_DN_CMP : ST_RESP;
         ST_DN_CMP: state_in = (pick_left || pick_right) ? ST_DN : ST_RESP;
         ST_RESP:   state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory control and result
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      carry_in  = carry_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = carry_ff;
      rd_addr_a = parent_idx;
      rd_addr_b = right_idx[IDX_W-1:0];
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               status_in = STAT_OK;
               carry_in  = req_entry;
               if (req_tuser == REQ_PUSH) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                  end else begin
                     idx_in   = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_UP: begin
            // Reached the root: drop the element there
            if (idx_ff == '0) begin
               wr_en = 1'b1;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (climb) begin
               wr_data = rd_a;
               idx_in  = parent_idx;
            end
         end
         ST_POP_RD: begin
            rd_addr_a = count_ff[IDX_W-1:0];
         end
         ST_POP_LD: begin
            carry_in = rd_a;
            idx_in   = '0;
         end
         ST_DN: begin
            rd_addr_a = left_idx[IDX_W-1:0];
            // No child: the element settles here
            if (!left_ok) begin
               wr_en = 1'b1;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (pick_right) begin
               wr_data = rd_b;
               idx_in  = right_idx[IDX_W-1:0];
            end else if (pick_left) begin
               wr_data = rd_a;
               idx_in  = left_idx[IDX_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Mirror of the root entry
   always_comb begin
      top_in = top_ff;
      if (wr_en && (wr_addr == '0)) begin
         top_in = wr_data;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (count_ff == '0) begin
            rsp_data_in = {RSP_PAD_W'(0), count_ff, ENTRY_W'(0)};
            rsp_user_in = {status_ff, 1'b1};
         end else begin
            rsp_data_in = {RSP_PAD_W'(0), count_ff, top_ff};
            rsp_user_in = {status_ff, 1'b0};
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      carry_ff    <= carry_in;
      top_ff      <= top_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // A transfer makes the unit busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken while busy");

   // Memory writes happen only while sifting
   a_write_in_sift: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UP || state_ff == ST_UP_CMP ||
                 state_ff == ST_DN || state_ff == ST_DN_CMP))
      else $error("heap write outside a sift");

   // An empty result carries a zero count and zero top
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_data_ff[ENTRY_W+CNT_W-1:0] == '0))
      else $error("empty result with nonzero fields");

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the max-heap priority queue. A software heap tracks
// every accepted push and pop and predicts the top element, element count,
// empty flag and status of each result. Directed cases come first, then
// random request mixes that fill the heap to capacity and drain it again.
// Both channels stall at random, and the result side holds off long enough
// to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import mhpq_pkg::*;

   // Predicted view of the heap after one request
   typedef struct {
      logic [TAG_W-1:0]         top_tag;
      logic signed [PRIO_W-1:0] top_prio;
      logic [CNT_W-1:0]         total;
      logic                     empty;
      status_type               status;
   } heap_view_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [31:0] item_tag, [47:32] item_priority
   logic                  req_tuser = 1'b0; // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [31:0] top_tag, [47:32] top_priority,
                                            // [58:48] element_total, [63:59] zero
   logic [RSP_USER_W-1:0] rsp_tuser;        // [0] is_empty, [2:1] status

   // Software copy of the heap
   logic [TAG_W-1:0]         model_tag  [CAPACITY];
   logic signed [PRIO_W-1:0] model_prio [CAPACITY];
   int unsigned              model_count = 0;

   heap_view_type awaited_views[$];
   int            error_count     = 0;
   int            req_idle_pct    = 30;
   int            rsp_idle_pct    = 30;
   int            rsp_hold_cycles = 0;

   max_heap_priority_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [TAG_W-1:0]         hold_tag;
      logic signed [PRIO_W-1:0] hold_prio;
      hold_tag      = model_tag[a];
      hold_prio     = model_prio[a];
      model_tag[a]  = model_tag[b];
      model_prio[a] = model_prio[b];
      model_tag[b]  = hold_tag;
      model_prio[b] = hold_prio;
   endfunction

   // Apply one request to the software heap and queue the expected view
   function automatic void predict_request(req_kind_type kind, logic [TAG_W-1:0] tag,
                                           logic signed [PRIO_W-1:0] prio);
      heap_view_type view;
      int unsigned   slot;
      int unsigned   parent;
      int unsigned   left;
      int unsigned   right;
      int unsigned   best;
      view.status = STAT_OK;
      if (kind == REQ_PUSH) begin
         if (model_count >= CAPACITY) begin
            view.status = STAT_FULL;
         end else begin
            // append, then climb while strictly greater than the parent
            slot = model_count;
            model_tag[slot]  = tag;
            model_prio[slot] = prio;
            model_count++;
            while (slot > 0) begin
               parent = (slot - 1) / 2;
               if (model_prio[slot] <= model_prio[parent]) break;
               swap_slots(slot, parent);
               slot = parent;
            end
         end
      end else begin
         if (model_count == 0) begin
            view.status = STAT_EMPTY;
         end else begin
            // move the last element to the root and sink it, left child wins ties
            model_count--;
            model_tag[0]  = model_tag[model_count];
            model_prio[0] = model_prio[model_count];
            slot = 0;
            forever begin
               left  = 2 * slot + 1;
               right = 2 * slot + 2;
               best  = slot;
               if (left < model_count && model_prio[left] > model_prio[best]) best = left;
               if (right < model_count && model_prio[right] > model_prio[best]) best = right;
               if (best == slot) break;
               swap_slots(slot, best);
               slot = best;
            end
         end
      end
      view.empty    = (model_count == 0);
      view.top_tag  = view.empty ? '0 : model_tag[0];
      view.top_prio = view.empty ? '0 : model_prio[0];
      view.total    = CNT_W'(model_count);
      awaited_views.push_back(view);
   endfunction

   function automatic logic signed [PRIO_W-1:0] random_priority();
      logic signed [PRIO_W-1:0] p;
      case ($urandom_range(0, 9))
         0, 1, 2: p = PRIO_W'($urandom);
         // narrow band to provoke ties
         3, 4, 5: p = PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
         6:       p = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         default: p = PRIO_W'($urandom_range(0, 2000)) - PRIO_W'(1000);
      endcase
      return p;
   endfunction

   // Offer one request, hold it until the transfer, then maybe idle
   task automatic send_request(req_kind_type kind, logic [TAG_W-1:0] tag,
                               logic signed [PRIO_W-1:0] prio);
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, tag};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(kind, tag, prio);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
   endtask

   task automatic run_random_requests(int count, int push_pct);
      repeat (count) begin
         send_request(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP,
                      $urandom, random_priority());
      end
   endtask

   // Empty pops, priority extremes, ties on push and on pop
   task automatic test_directed_cases();
      send_request(REQ_POP,  32'h0000_0000, 16'sh0000);
      send_request(REQ_PUSH, 32'hFFFF_FFFF, 16'sh8000);
      send_request(REQ_PUSH, 32'h0000_0000, 16'sh7FFF);
      send_request(REQ_PUSH, 32'h1234_5678, 16'sh0000);
      send_request(REQ_PUSH, 32'h0000_0001, 16'sh7FFF);
      send_request(REQ_PUSH, 32'hA5A5_A5A5, 16'shFFFF);
      send_request(REQ_PUSH, 32'h5A5A_5A5A, 16'sh0064);
      send_request(REQ_PUSH, 32'hC3C3_C3C3, 16'sh0064);
      repeat (7) send_request(REQ_POP, $urandom, random_priority());
      send_request(REQ_POP,  32'hFFFF_FFFF, 16'sh7FFF);
      // a zero tag and priority pushed onto the empty heap
      send_request(REQ_PUSH, 32'h0000_0000, 16'sh0000);
      send_request(REQ_POP,  32'h0000_0000, 16'sh8000);
      send_request(REQ_PUSH, 32'h8000_0000, 16'sh7FFE);
      send_request(REQ_PUSH, 32'h7FFF_FFFF, 16'sh8001);
      send_request(REQ_POP,  32'h0F0F_0F0F, 16'sh1234);
      send_request(REQ_POP,  32'hF0F0_F0F0, 16'shEDCB);
      wait_drained();
   endtask

   // Hold the result side off while the sender keeps offering
   task automatic test_output_backpressure();
      req_idle_pct    = 0;
      rsp_hold_cycles = 200;
      repeat (10) send_request(REQ_PUSH, $urandom, random_priority());
      wait_drained();
   endtask

   task automatic test_random_mix();
      req_idle_pct = 25;
      rsp_idle_pct = 25;
      run_random_requests(250, 65);
   endtask

   // Push up to capacity, overflow, then work at the full boundary
   task automatic test_fill_to_capacity();
      req_idle_pct = 15;
      rsp_idle_pct = 15;
      while (model_count < CAPACITY) send_request(REQ_PUSH, $urandom, random_priority());
      repeat (5) send_request(REQ_PUSH, $urandom, random_priority());
      run_random_requests(40, 50);
   endtask

   // Deep sift-down pops; finish without idling
   task automatic test_drain_pops();
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      run_random_requests(330, 5);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_requests(150, 60);
   endtask

   // Result side: random stall bursts and long hold-offs
   initial begin : rsp_sink
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            repeat (hold) @(posedge clock);
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each result transfer with the oldest predicted view
   always @(posedge clock) begin : check_results
      heap_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_views.size() == 0) begin
            $error("unexpected result: tdata %h tuser %h", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = awaited_views.pop_front();
            if (rsp_tdata[TAG_W-1:0] !== want.top_tag) begin
               $error("top_tag: expected %h, got %h", want.top_tag, rsp_tdata[TAG_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[ENTRY_W-1:TAG_W] !== want.top_prio) begin
               $error("top_priority: expected %0d, got %0d", want.top_prio,
                      $signed(rsp_tdata[ENTRY_W-1:TAG_W]));
               error_count++;
            end
            if (rsp_tdata[ENTRY_W+CNT_W-1:ENTRY_W] !== want.total) begin
               $error("element_total: expected %0d, got %0d", want.total,
                      rsp_tdata[ENTRY_W+CNT_W-1:ENTRY_W]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.empty) begin
               $error("is_empty: expected %0b, got %0b", want.empty, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[2:1] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser[2:1]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_output_backpressure();
      test_random_mix();
      test_fill_to_capacity();
      test_drain_pops();
      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- max_heap_priority_queue_unit.f -----
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/max_heap_priority_queue_unit.sv
verif/tb_top.sv
